// ===== hw/rtl/sbcs_pkg.sv =====
// Shared types, widths and side codes for the swept box collision side block.
// Depends on nothing; every other file in hw/rtl imports it.
package sbcs_pkg;

   localparam int POS_W = 10;
   localparam int VEL_W = 8;
   localparam int EDGE_W = POS_W + 1;
   localparam int SIDE_W = 3;
   localparam int TIME_SCALE_DEF = 16;
   localparam int DIV_BITS_PER_STAGE = 2;

   typedef enum logic [SIDE_W-1:0] {
      SIDE_NONE   = 3'd0,
      SIDE_TOP    = 3'd1,
      SIDE_RIGHT  = 3'd2,
      SIDE_BOTTOM = 3'd3,
      SIDE_LEFT   = 3'd4
   } side_type;

   // Tangential part of one side test: the mover's span, the still span and
   // the velocity along the side.
   typedef struct packed {
      logic [EDGE_W-1:0]       lo;
      logic [EDGE_W-1:0]       hi;
      logic [EDGE_W-1:0]       olo;
      logic [EDGE_W-1:0]       ohi;
      logic signed [VEL_W-1:0] vt;
   } span_type;

   typedef struct packed {
      logic [EDGE_W-1:0]       edge_pos;
      logic [EDGE_W-1:0]       target_pos;
      logic signed [VEL_W-1:0] vn;
      span_type                span;
   } side_in_type;

   function automatic int time_bits(int scale);
      return $clog2(scale + 1);
   endfunction

   // Register stages inside one side lane: preparation, division, products.
   function automatic int lane_stages(int scale);
      return (time_bits(scale) + DIV_BITS_PER_STAGE - 1) / DIV_BITS_PER_STAGE + 2;
   endfunction

endpackage

// ===== hw/rtl/sbcs_lane.sv =====
// One side test as a pipeline: gap scaling, restoring division, span products.
// Depends on sbcs_pkg.
module sbcs_lane #(
   parameter int TIME_SCALE = sbcs_pkg::TIME_SCALE_DEF
) (
   input  logic                                         clock,
   input  logic [sbcs_pkg::lane_stages(TIME_SCALE)-1:0] ld,
   input  sbcs_pkg::side_in_type                        side_in,
   output logic                                         hit
);
   import sbcs_pkg::*;

   localparam int TW = time_bits(TIME_SCALE);
   localparam int BPS = DIV_BITS_PER_STAGE;
   localparam int DS = (TW + BPS - 1) / BPS;
   localparam int NW = EDGE_W + TW;
   localparam int AW = NW + 2;
   localparam int GW = EDGE_W + 1;
   localparam int PW = TW + VEL_W + 1;
   localparam logic [TW-1:0] T_MAX = TW'(TIME_SCALE);

   // Preparation: magnitude of the scaled gap and of the normal velocity.
   logic [GW-1:0]     gap;
   logic [GW-1:0]     gap_mag;
   logic [VEL_W-1:0]  vn_mag;
   logic [NW-1:0]     num_mag;
   logic [NW-1:0]     dvs_top;

   logic [NW-1:0]     rem_ff [DS+1];
   logic [TW-1:0]     quo_ff [DS+1];
   logic [VEL_W-1:0]  dvs_ff [DS+1];
   logic              bad_ff [DS+1];
   logic              neg_ff [DS+1];
   span_type          span_ff [DS+1];

   always_comb begin
      gap = {1'b0, side_in.target_pos} - {1'b0, side_in.edge_pos};
      gap_mag = gap[GW-1] ? (~gap + 1'b1) : gap;
      vn_mag = side_in.vn[VEL_W-1] ? (~side_in.vn + 1'b1) : side_in.vn;
      num_mag = NW'(gap_mag[EDGE_W-1:0]) * NW'(TIME_SCALE);
      dvs_top = NW'(vn_mag) << TW;
   end

   // A zero velocity makes the divisor zero, so it lands in the same
   // out-of-range flag as a quotient too large for the time field.
   always_ff @(posedge clock) begin
      if (ld[0]) begin
         rem_ff[0]  <= num_mag;
         quo_ff[0]  <= '0;
         dvs_ff[0]  <= vn_mag;
         bad_ff[0]  <= (num_mag >= dvs_top);
         neg_ff[0]  <= gap[GW-1] ^ side_in.vn[VEL_W-1];
         span_ff[0] <= side_in.span;
      end
   end

   for (genvar d = 1; d <= DS; d++) begin : g_div
      logic [NW-1:0] rem_in;
      logic [TW-1:0] quo_in;

      always_comb begin
         logic [NW-1:0] trial;
         trial = '0;
         rem_in = rem_ff[d-1];
         quo_in = quo_ff[d-1];
         for (int i = 0; i < BPS; i++) begin
            if ((d - 1) * BPS + i < TW) begin
               trial = NW'(dvs_ff[d-1]) << (TW - 1 - ((d - 1) * BPS + i));
               quo_in = quo_in << 1;
               if (rem_in >= trial) begin
                  rem_in = rem_in - trial;
                  quo_in = quo_in | TW'(1);
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (ld[d]) begin
            rem_ff[d]  <= rem_in;
            quo_ff[d]  <= quo_in;
            dvs_ff[d]  <= dvs_ff[d-1];
            bad_ff[d]  <= bad_ff[d-1];
            neg_ff[d]  <= neg_ff[d-1];
            span_ff[d] <= span_ff[d-1];
         end
      end
   end

   // Time check and the shifted span ends, all scaled by the time scale.
   logic [TW-1:0]             t_val;
   logic                      ok_in;
   logic signed [TW+VEL_W:0]  tv;
   logic [NW-1:0]             lo_s, hi_s, olo_s, ohi_s;
   logic signed [AW-1:0]      a0_in, a1_in;

   logic                      ok_ff;
   logic signed [AW-1:0]      a0_ff, a1_ff;
   logic [NW-1:0]             olo_ff, ohi_ff;

   always_comb begin
      t_val = quo_ff[DS];
      ok_in = !bad_ff[DS] && (t_val <= T_MAX) && (!neg_ff[DS] || (t_val == '0));
      tv = PW'($signed({1'b0, t_val})) * PW'(span_ff[DS].vt);
      lo_s = NW'(span_ff[DS].lo) * NW'(TIME_SCALE);
      hi_s = NW'(span_ff[DS].hi) * NW'(TIME_SCALE);
      olo_s = NW'(span_ff[DS].olo) * NW'(TIME_SCALE);
      ohi_s = NW'(span_ff[DS].ohi) * NW'(TIME_SCALE);
      a0_in = $signed(AW'(lo_s)) + AW'(tv);
      a1_in = $signed(AW'(hi_s)) + AW'(tv);
   end

   always_ff @(posedge clock) begin
      if (ld[DS+1]) begin
         ok_ff  <= ok_in;
         a0_ff  <= a0_in;
         a1_ff  <= a1_in;
         olo_ff <= olo_s;
         ohi_ff <= ohi_s;
      end
   end

   assign hit = ok_ff && !(a1_ff < $signed(AW'(olo_ff))) && !($signed(AW'(ohi_ff)) < a0_ff);

endmodule

// ===== hw/rtl/swept_box_collision_side_top.sv =====
// Top level of the swept box collision side block: input stage, four side
// lanes, priority encoding and output register. Depends on sbcs_pkg, sbcs_lane.
//
// Usage. A request on the req_ channel carries one moving box (position, size
// and signed velocity) and one still box. For each request exactly one
// response leaves on the rsp_ channel, in request order: rsp_hit_side names
// a side of the mover that meets the still box within one step, the first
// in the order 1 top, 2 right, 3 bottom, 4 left, or 0 when no side does.
// Both channels use a valid/ready handshake.
//
// The pipeline has ceil(clog2(TIME_SCALE+1)/2) + 4 register stages. The depth
// is set by the restoring divider in each lane, which resolves two quotient
// bits per stage. Throughput is one request per cycle while responses are
// taken or a stage is empty; the four sides are tested in parallel.
//
// Every stage carries a valid bit and loads whenever it is empty or its
// contents move on, so bubbles close up. When the receiver stalls, the
// response waits in the output register and earlier stages keep accepting
// requests until the pipeline is full; nothing is lost or repeated.
// Reset (synchronous, active high) empties every stage; no response is
// pending afterwards and the block is ready in the following cycle.
module swept_box_collision_side_top #(
   parameter int TIME_SCALE = sbcs_pkg::TIME_SCALE_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [sbcs_pkg::POS_W-1:0]   req_mover_left,
   input  logic [sbcs_pkg::POS_W-1:0]   req_mover_top,
   input  logic [sbcs_pkg::POS_W-1:0]   req_mover_width,
   input  logic [sbcs_pkg::POS_W-1:0]   req_mover_height,
   input  logic signed [sbcs_pkg::VEL_W-1:0] req_mover_vel_x,
   input  logic signed [sbcs_pkg::VEL_W-1:0] req_mover_vel_y,
   input  logic [sbcs_pkg::POS_W-1:0]   req_still_left,
   input  logic [sbcs_pkg::POS_W-1:0]   req_still_top,
   input  logic [sbcs_pkg::POS_W-1:0]   req_still_width,
   input  logic [sbcs_pkg::POS_W-1:0]   req_still_height,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [sbcs_pkg::SIDE_W-1:0]  rsp_hit_side
);
   import sbcs_pkg::*;

   // Input stage, the lane stages and the output stage.
   localparam int LS = lane_stages(TIME_SCALE);
   localparam int NST = LS + 2;
   localparam int LAST = NST - 1;

   logic [NST-1:0] vld_ff;
   logic [NST-1:0] vld_in;
   logic [NST:0]   ld;

   // A stage loads when it is empty or its item moves on; the chain starts at
   // the receiver's ready, so a stalled output holds everything behind it
   // only once the stages in between are full.
   always_comb begin
      ld[NST] = rsp_ready;
      for (int i = NST - 1; i >= 0; i--) begin
         ld[i] = !vld_ff[i] || ld[i+1];
      end
      vld_in[0] = ld[0] ? req_valid : vld_ff[0];
      for (int i = 1; i < NST; i++) begin
         vld_in[i] = ld[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_ready = ld[0];
   assign rsp_valid = vld_ff[LAST];

   // Input stage: box edges are formed here, right and bottom without wrap.
   logic [EDGE_W-1:0]       ml_ff, mt_ff, mr_ff, mb_ff;
   logic [EDGE_W-1:0]       sl_ff, st_ff, sr_ff, sb_ff;
   logic signed [VEL_W-1:0] vx_ff, vy_ff;

   always_ff @(posedge clock) begin
      if (ld[0]) begin
         ml_ff <= EDGE_W'(req_mover_left);
         mt_ff <= EDGE_W'(req_mover_top);
         mr_ff <= EDGE_W'(req_mover_left) + EDGE_W'(req_mover_width);
         mb_ff <= EDGE_W'(req_mover_top) + EDGE_W'(req_mover_height);
         sl_ff <= EDGE_W'(req_still_left);
         st_ff <= EDGE_W'(req_still_top);
         sr_ff <= EDGE_W'(req_still_left) + EDGE_W'(req_still_width);
         sb_ff <= EDGE_W'(req_still_top) + EDGE_W'(req_still_height);
         vx_ff <= req_mover_vel_x;
         vy_ff <= req_mover_vel_y;
      end
   end

   // Each mover side faces the opposite side of the still box. Top and bottom
   // slide along x, right and left along y.
   side_in_type side_in [4];
   logic [3:0]  hit;
   span_type    span_x;
   span_type    span_y;

   always_comb begin
      span_x = '{lo: ml_ff, hi: mr_ff, olo: sl_ff, ohi: sr_ff, vt: vx_ff};
      span_y = '{lo: mt_ff, hi: mb_ff, olo: st_ff, ohi: sb_ff, vt: vy_ff};
      side_in[0] = '{edge_pos: mt_ff, target_pos: sb_ff, vn: vy_ff, span: span_x};
      side_in[1] = '{edge_pos: mr_ff, target_pos: sl_ff, vn: vx_ff, span: span_y};
      side_in[2] = '{edge_pos: mb_ff, target_pos: st_ff, vn: vy_ff, span: span_x};
      side_in[3] = '{edge_pos: ml_ff, target_pos: sr_ff, vn: vx_ff, span: span_y};
   end

   for (genvar s = 0; s < 4; s++) begin : g_side
      sbcs_lane #(
         .TIME_SCALE (TIME_SCALE)
      ) u_lane (
         .clock   (clock),
         .ld      (ld[LS:1]),
         .side_in (side_in[s]),
         .hit     (hit[s])
      );
   end

   // Output stage: the first side in test order wins.
   side_type side_in_sel;
   side_type side_ff;

   always_comb begin
      if (hit[0]) begin
         side_in_sel = SIDE_TOP;
      end else if (hit[1]) begin
         side_in_sel = SIDE_RIGHT;
      end else if (hit[2]) begin
         side_in_sel = SIDE_BOTTOM;
      end else if (hit[3]) begin
         side_in_sel = SIDE_LEFT;
      end else begin
         side_in_sel = SIDE_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (ld[LAST]) begin
         side_ff <= side_in_sel;
      end
   end

   assign rsp_hit_side = side_ff;

endmodule

// ===== hw/rtl/sbcs_checker.sv =====
// Port-level checks for the swept box collision side block, bound to the top.
// Depends on sbcs_pkg and swept_box_collision_side_top.
module sbcs_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [sbcs_pkg::SIDE_W-1:0] rsp_hit_side
);
   import sbcs_pkg::*;

   // Only the five side codes may ever be reported.
   a_side_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hit_side <= SIDE_LEFT))
      else $error("response carries an unknown side code");

   // Reset leaves no response pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response pending right after reset");

   // A taking receiver lets the whole pipeline move, so requests are taken.
   a_ready_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("request refused while the receiver takes responses");

   // A stalled response stays, unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit_side))
      else $error("stalled response dropped or changed");

endmodule

bind swept_box_collision_side_top sbcs_checker u_sbcs_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_hit_side (rsp_hit_side)
);
